// ===== src/hdec_pkg.sv =====
`timescale 1ns / 1ps

package hdec_pkg;

    // Operation codes carried in the op field of an input transaction.
    localparam logic [1:0] OP_LOAD = 2'd0;
    localparam logic [1:0] OP_DATA = 2'd1;
    localparam logic [1:0] OP_END  = 2'd2;

    // Configuration register indexes.
    localparam logic CFG_TOTAL = 1'b0;
    localparam logic CFG_ROOT  = 1'b1;

    localparam int CFG_DATA_W = 32;
    localparam int IDX_W      = 9;
    localparam int SYM_W      = 8;

    typedef struct packed {
        logic [1:0]       op;
        logic [IDX_W-1:0] node_index;
        logic             node_is_leaf;
        logic [SYM_W-1:0] node_symbol;
        logic [IDX_W-1:0] left_child;
        logic [IDX_W-1:0] right_child;
        logic [7:0]       data_byte;
    } t_in_item;

    typedef struct packed {
        logic [SYM_W-1:0] symbol;
        logic             is_status;
        logic             status;
        logic             last;
    } t_out_item;

    typedef enum logic [2:0] {
        S_IDLE,
        S_CUR,
        S_NEXT,
        S_FLUSH,
        S_STATUS
    } t_state;

endpackage

// ===== src/hdec_in_if.sv =====
`timescale 1ns / 1ps

interface hdec_in_if;
    logic                 valid;
    logic                 ready;
    hdec_pkg::t_in_item   data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

// ===== src/hdec_out_if.sv =====
`timescale 1ns / 1ps

interface hdec_out_if;
    logic                 valid;
    logic                 ready;
    hdec_pkg::t_out_item  data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

// ===== src/hdec_node_ram.sv =====
`timescale 1ns / 1ps

// Node table: one write port and one read port with registered read data.
module hdec_node_ram #(
    parameter int DEPTH = 512,
    parameter int AW    = 9,
    parameter int DW    = 27
) (
    input  logic          i_clk,
    input  logic          i_we,
    input  logic [AW-1:0] i_waddr,
    input  logic [DW-1:0] i_wdata,
    input  logic          i_re,
    input  logic [AW-1:0] i_raddr,
    output logic [DW-1:0] o_rdata
);

    logic [DW-1:0] r_mem [DEPTH];
    logic [DW-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // Read data holds while no read is issued, so a stalled walk keeps its node.
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ===== src/hdec_walker.sv =====
`timescale 1ns / 1ps

// Tree-walk sequencer: one node table read per step, a pending symbol stage
// so the last flag can be set once the byte ends, and an output register.
module hdec_walker #(
    parameter int NODE_COUNT = 512,
    parameter int AW         = 9,
    parameter int EW         = 27
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    hdec_in_if.sink                         i_in,
    hdec_out_if.source                      o_out,
    input  logic                            i_cfg_we,
    input  logic                            i_cfg_idx,
    input  logic [hdec_pkg::CFG_DATA_W-1:0] i_cfg_data,
    output logic                            o_ram_we,
    output logic [AW-1:0]                   o_ram_waddr,
    output logic [EW-1:0]                   o_ram_wdata,
    output logic                            o_ram_re,
    output logic [AW-1:0]                   o_ram_raddr,
    input  logic [EW-1:0]                   i_ram_rdata
);

    // Reduces a 9-bit index modulo NODE_COUNT by restoring compare-subtract steps.
    function automatic logic [AW-1:0] wrap_idx(input logic [hdec_pkg::IDX_W-1:0] x);
        logic [12:0] v;
        v = 13'(x);
        for (int k = 8; k >= 0; k--) begin
            if ((NODE_COUNT << k) <= 511) begin
                if (v >= 13'(NODE_COUNT << k)) begin
                    v = v - 13'(NODE_COUNT << k);
                end
            end
        end
        return v[AW-1:0];
    endfunction

    hdec_pkg::t_state    r_state, n_state;
    logic [31:0]         r_total, n_total;
    logic [AW-1:0]       r_root, n_root;
    logic [AW-1:0]       r_walk, n_walk;
    logic [AW-1:0]       r_next, n_next;
    logic [31:0]         r_done, n_done;
    logic [7:0]          r_byte, n_byte;
    logic [2:0]          r_bit, n_bit;
    logic                r_pend_valid, n_pend_valid;
    logic [7:0]          r_pend_sym, n_pend_sym;
    logic                r_out_valid, n_out_valid;
    hdec_pkg::t_out_item r_out, n_out;

    logic          in_fire;
    logic          out_free;
    logic          can_emit;
    logic          node_leaf;
    logic [7:0]    node_sym;
    logic [AW-1:0] node_left;
    logic [AW-1:0] node_right;
    logic          bit_now;
    logic          bit_after;
    logic [31:0]   done_inc;
    logic          total_hit;

    assign in_fire    = i_in.valid && i_in.ready;
    assign out_free   = !r_out_valid || o_out.ready;
    assign can_emit   = !r_pend_valid || out_free;
    assign node_leaf  = i_ram_rdata[EW-1];
    assign node_sym   = i_ram_rdata[EW-2 -: 8];
    assign node_left  = i_ram_rdata[2*AW-1 -: AW];
    assign node_right = i_ram_rdata[AW-1:0];
    assign bit_now    = r_byte[r_bit];
    assign bit_after  = r_byte[r_bit - 3'd1];
    assign done_inc   = (r_done == 32'hFFFF_FFFF) ? r_done : r_done + 32'd1;
    assign total_hit  = (done_inc >= r_total);

    assign i_in.ready  = (r_state == hdec_pkg::S_IDLE);
    assign o_out.valid = r_out_valid;
    assign o_out.data  = r_out;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= hdec_pkg::S_IDLE;
            r_total      <= '0;
            r_root       <= '0;
            r_walk       <= '0;
            r_done       <= '0;
            r_pend_valid <= 1'b0;
            r_out_valid  <= 1'b0;
        end else begin
            r_state      <= n_state;
            r_total      <= n_total;
            r_root       <= n_root;
            r_walk       <= n_walk;
            r_done       <= n_done;
            r_pend_valid <= n_pend_valid;
            r_out_valid  <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_next     <= n_next;
        r_byte     <= n_byte;
        r_bit      <= n_bit;
        r_pend_sym <= n_pend_sym;
        r_out      <= n_out;
    end

    always_comb begin
        n_state      = r_state;
        n_total      = r_total;
        n_root       = r_root;
        n_walk       = r_walk;
        n_next       = r_next;
        n_done       = r_done;
        n_byte       = r_byte;
        n_bit        = r_bit;
        n_pend_valid = r_pend_valid;
        n_pend_sym   = r_pend_sym;
        n_out_valid  = r_out_valid;
        n_out        = r_out;
        o_ram_we     = 1'b0;
        o_ram_waddr  = wrap_idx(i_in.data.node_index);
        o_ram_wdata  = {i_in.data.node_is_leaf, i_in.data.node_symbol,
                        wrap_idx(i_in.data.left_child), wrap_idx(i_in.data.right_child)};
        o_ram_re     = 1'b0;
        o_ram_raddr  = r_walk;

        if (r_out_valid && o_out.ready) begin
            n_out_valid = 1'b0;
        end

        case (r_state)
            hdec_pkg::S_IDLE: begin
                if (in_fire) begin
                    case (i_in.data.op)
                        hdec_pkg::OP_LOAD: begin
                            o_ram_we = 1'b1;
                        end
                        hdec_pkg::OP_DATA: begin
                            n_byte = i_in.data.data_byte;
                            n_bit  = 3'd7;
                            if (r_done < r_total) begin
                                o_ram_re    = 1'b1;
                                o_ram_raddr = r_walk;
                                n_state     = hdec_pkg::S_CUR;
                            end
                        end
                        hdec_pkg::OP_END: begin
                            n_state = hdec_pkg::S_STATUS;
                        end
                        default: begin
                        end
                    endcase
                end
            end
            hdec_pkg::S_CUR, hdec_pkg::S_NEXT: begin
                if (node_leaf) begin
                    if (can_emit) begin
                        if (r_pend_valid) begin
                            n_out_valid     = 1'b1;
                            n_out.symbol    = r_pend_sym;
                            n_out.is_status = 1'b0;
                            n_out.status    = 1'b0;
                            n_out.last      = 1'b0;
                        end
                        n_pend_valid = 1'b1;
                        n_pend_sym   = node_sym;
                        n_walk       = r_root;
                        n_done       = done_inc;
                        if (r_bit == 3'd0 || total_hit) begin
                            n_state = hdec_pkg::S_FLUSH;
                        end else begin
                            n_bit       = r_bit - 3'd1;
                            o_ram_re    = 1'b1;
                            o_ram_raddr = r_root;
                            n_state     = hdec_pkg::S_CUR;
                        end
                    end
                end else if (r_state == hdec_pkg::S_CUR) begin
                    n_next      = bit_now ? node_right : node_left;
                    o_ram_re    = 1'b1;
                    o_ram_raddr = n_next;
                    n_state     = hdec_pkg::S_NEXT;
                end else begin
                    // The child just read is an inner node: it becomes the walk
                    // position; with bits left, its child is read for the next bit.
                    n_walk = r_next;
                    if (r_bit == 3'd0) begin
                        n_state = hdec_pkg::S_FLUSH;
                    end else begin
                        n_bit       = r_bit - 3'd1;
                        n_next      = bit_after ? node_right : node_left;
                        o_ram_re    = 1'b1;
                        o_ram_raddr = n_next;
                    end
                end
            end
            hdec_pkg::S_FLUSH: begin
                if (!r_pend_valid) begin
                    n_state = hdec_pkg::S_IDLE;
                end else if (out_free) begin
                    n_out_valid     = 1'b1;
                    n_out.symbol    = r_pend_sym;
                    n_out.is_status = 1'b0;
                    n_out.status    = 1'b0;
                    n_out.last      = 1'b1;
                    n_pend_valid    = 1'b0;
                    n_state         = hdec_pkg::S_IDLE;
                end
            end
            hdec_pkg::S_STATUS: begin
                if (out_free) begin
                    n_out_valid     = 1'b1;
                    n_out.symbol    = 8'd0;
                    n_out.is_status = 1'b1;
                    n_out.status    = (r_done != r_total);
                    n_out.last      = 1'b1;
                    n_walk          = r_root;
                    n_done          = '0;
                    n_state         = hdec_pkg::S_IDLE;
                end
            end
            default: begin
                n_state = hdec_pkg::S_IDLE;
            end
        endcase

        if (i_cfg_we) begin
            case (i_cfg_idx)
                hdec_pkg::CFG_TOTAL: begin
                    n_total = i_cfg_data;
                end
                hdec_pkg::CFG_ROOT: begin
                    n_root = wrap_idx(i_cfg_data[hdec_pkg::IDX_W-1:0]);
                    n_walk = wrap_idx(i_cfg_data[hdec_pkg::IDX_W-1:0]);
                end
                default: begin
                end
            endcase
        end
    end

`ifndef SYNTH
    a_idle_no_pending: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == hdec_pkg::S_IDLE) |-> !r_pend_valid)
        else $error("pending symbol left over after a byte finished");

    a_load_stays_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_fire && i_in.data.op == hdec_pkg::OP_LOAD) |=> (r_state == hdec_pkg::S_IDLE))
        else $error("node load left the idle state");

    a_done_steps: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_done == $past(r_done)) || (r_done == $past(r_done) + 32'd1) || (r_done == 32'd0))
        else $error("decoded symbol count jumped");

    a_symbol_status_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !r_out.is_status) |-> (!r_out.status))
        else $error("symbol result carries a status flag");
`endif

endmodule

// ===== src/huffman_tree_byte_decoder.sv =====
`timescale 1ns / 1ps

// Huffman tree-walk decoder.
// The input channel i_in takes three kinds of transactions: a node load writes
// one node table entry, a data byte is decoded most significant bit first, and
// an end-of-stream transaction returns one status result and rewinds the walk.
// Each decoded symbol leaves on o_out as one transaction; the final result of
// an input transaction carries last. The configuration port writes the symbol
// total (index 0) and the root index (index 1); the user must do so only while
// the block is idle, and the block itself does not enforce it. A data byte
// takes one node table read for its first bit and for each bit that begins at
// the root, plus one read for each bit whose walk leaves an inner node (the
// single read port sets the pace), then releases its last symbol; the symbol
// total can cut a byte short. One transaction is in flight at a time;
// i_in.ready is high only between transactions.
// Reset clears the walk to node 0, the counts and both registers; the node
// table keeps its contents and must be loaded before use.
// A stalled receiver holds the decoded symbol in the output register and the
// walk waits until the register frees, so no result is lost.
module huffman_tree_byte_decoder #(
    parameter int NODE_COUNT = 512
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    hdec_in_if.sink                         i_in,
    hdec_out_if.source                      o_out,
    input  logic                            i_cfg_we,
    input  logic                            i_cfg_idx,
    input  logic [hdec_pkg::CFG_DATA_W-1:0] i_cfg_data
);

    // Table address width and entry layout: leaf, symbol, left child, right child.
    localparam int AW = (NODE_COUNT > 1) ? $clog2(NODE_COUNT) : 1;
    localparam int EW = 1 + hdec_pkg::SYM_W + 2 * AW;

    logic          ram_we;
    logic [AW-1:0] ram_waddr;
    logic [EW-1:0] ram_wdata;
    logic          ram_re;
    logic [AW-1:0] ram_raddr;
    logic [EW-1:0] ram_rdata;

    hdec_walker #(
        .NODE_COUNT (NODE_COUNT),
        .AW         (AW),
        .EW         (EW)
    ) u_walker (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in        (i_in),
        .o_out       (o_out),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_data  (i_cfg_data),
        .o_ram_we    (ram_we),
        .o_ram_waddr (ram_waddr),
        .o_ram_wdata (ram_wdata),
        .o_ram_re    (ram_re),
        .o_ram_raddr (ram_raddr),
        .i_ram_rdata (ram_rdata)
    );

    hdec_node_ram #(
        .DEPTH (NODE_COUNT),
        .AW    (AW),
        .DW    (EW)
    ) u_node_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_re    (ram_re),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

endmodule

// ===== bench/huffman_decode_checker.sv =====
`timescale 1ns / 1ps

module huffman_decode_checker (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    hdec_in_if                              i_in,
    hdec_out_if                             i_out,
    input  logic                            i_cfg_we,
    input  logic                            i_cfg_idx,
    input  logic [hdec_pkg::CFG_DATA_W-1:0] i_cfg_data,
    output int                              o_mismatches,
    output int                              o_symbols_owed
);

    typedef struct packed {
        logic                       leaf;
        logic [hdec_pkg::SYM_W-1:0] sym;
        logic [hdec_pkg::IDX_W-1:0] left;
        logic [hdec_pkg::IDX_W-1:0] right;
    } t_tree_node;

    t_tree_node                 tree_nodes [0:511];
    logic [hdec_pkg::IDX_W-1:0] walk_at;
    logic [hdec_pkg::IDX_W-1:0] root_at;
    logic [31:0]                decoded_count;
    logic [31:0]                symbol_limit;
    hdec_pkg::t_out_item        symbols_due [$];
    int                         bad_count;

    // Walks the tree for one data byte and queues every symbol it yields.
    task automatic decode_byte(input logic [7:0] byte_in);
        t_tree_node                 cur;
        t_tree_node                 hit;
        logic [hdec_pkg::IDX_W-1:0] step_to;
        hdec_pkg::t_out_item        sym_out;
        int                         b;
        int                         queued;
        queued = 0;
        for (b = 7; b >= 0; b--) begin
            if (decoded_count >= symbol_limit) break;
            cur = tree_nodes[walk_at];
            if (cur.leaf) begin
                // A leaf under the walk eats the bit and yields its symbol.
                hit = cur;
            end else begin
                step_to = byte_in[b] ? cur.right : cur.left;
                hit = tree_nodes[step_to];
                if (!hit.leaf) begin
                    walk_at = step_to;
                    continue;
                end
            end
            sym_out = '0;
            sym_out.symbol = hit.sym;
            symbols_due.push_back(sym_out);
            queued++;
            walk_at = root_at;
            if (decoded_count != 32'hFFFF_FFFF) decoded_count++;
        end
        if (queued > 0) begin
            sym_out = symbols_due.pop_back();
            sym_out.last = 1'b1;
            symbols_due.push_back(sym_out);
        end
    endtask

    always @(posedge i_clk) begin : track
        hdec_pkg::t_out_item want;
        hdec_pkg::t_out_item got;
        hdec_pkg::t_in_item  item;
        if (!i_rst_n) begin
            walk_at       = '0;
            root_at       = '0;
            decoded_count = '0;
            symbol_limit  = '0;
            symbols_due.delete();
            bad_count     = 0;
        end else begin
            if (i_cfg_we) begin
                if (i_cfg_idx == hdec_pkg::CFG_TOTAL) begin
                    symbol_limit = i_cfg_data;
                end else begin
                    root_at = i_cfg_data[hdec_pkg::IDX_W-1:0];
                    walk_at = root_at;
                end
            end

            if (i_out.valid === 1'b1 && i_out.ready === 1'b1) begin
                got = i_out.data;
                if (symbols_due.size() == 0) begin
                    if (bad_count < 10)
                        $display("%0t: unexpected result: symbol %h status %b/%b last %b",
                                 $realtime, got.symbol, got.is_status, got.status, got.last);
                    bad_count++;
                end else begin
                    want = symbols_due.pop_front();
                    if (got.symbol !== want.symbol || got.is_status !== want.is_status ||
                        got.status !== want.status || got.last !== want.last) begin
                        if (bad_count < 10) begin
                            $write("%0t: mismatch: expected symbol %h status %b/%b last %b,",
                                   $realtime, want.symbol, want.is_status, want.status,
                                   want.last);
                            $display(" got symbol %h status %b/%b last %b",
                                     got.symbol, got.is_status, got.status, got.last);
                        end
                        bad_count++;
                    end
                end
            end

            if (i_in.valid === 1'b1 && i_in.ready === 1'b1) begin
                item = i_in.data;
                case (item.op)
                    hdec_pkg::OP_LOAD: begin
                        tree_nodes[item.node_index] = {item.node_is_leaf, item.node_symbol,
                                                       item.left_child, item.right_child};
                    end
                    hdec_pkg::OP_DATA: begin
                        decode_byte(item.data_byte);
                    end
                    hdec_pkg::OP_END: begin
                        want = '0;
                        want.is_status = 1'b1;
                        want.status = (decoded_count != symbol_limit);
                        want.last = 1'b1;
                        symbols_due.push_back(want);
                        walk_at = root_at;
                        decoded_count = '0;
                    end
                    default: begin
                    end
                endcase
            end
        end
        o_mismatches   <= bad_count;
        o_symbols_owed <= symbols_due.size();
    end

endmodule

// ===== bench/huffman_tree_byte_decoder_test.sv =====
`timescale 1ns / 1ps

// Testbench top for the Huffman tree-walk decoder. It makes all stimulus and
// gives the verdict; the checker beside the block predicts every result and
// counts mismatches.
module huffman_tree_byte_decoder_test;

    // The package has no name for the fourth op code, which the block ignores.
    localparam logic [1:0] OP_UNUSED = 2'd3;

    // The receiver's long hold-off, long enough for the block to back up.
    localparam int HOLD_CYCLES = 400;
    // Quiet time before a register write: longer than the slowest byte, so a
    // transaction that yields nothing has surely finished.
    localparam int QUIET_CYCLES = 30;
    // Random transactions per idling phase; ignored op codes do not count.
    localparam int PHASE_ITEMS = 120;

    logic                            i_clk = 1'b0;
    logic                            i_rst_n;
    logic                            i_cfg_we;
    logic                            i_cfg_idx;
    logic [hdec_pkg::CFG_DATA_W-1:0] i_cfg_data;

    hdec_in_if  in_ch ();
    hdec_out_if out_ch ();

    int                         mismatches;
    int                         results_owed;
    int                         send_idle_pct;
    int                         sink_stall_pct;
    logic                       hold_start;
    int                         hold_left;
    int                         item_count;
    bit                         tree_used [0:511];
    logic [hdec_pkg::IDX_W-1:0] loaded_nodes [$];

    always #5 i_clk = ~i_clk;

    huffman_tree_byte_decoder u_dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in       (in_ch),
        .o_out      (out_ch),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data)
    );

    huffman_decode_checker u_check (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in           (in_ch),
        .i_out          (out_ch),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_idx      (i_cfg_idx),
        .i_cfg_data     (i_cfg_data),
        .o_mismatches   (mismatches),
        .o_symbols_owed (results_owed)
    );

    // Receiver side. A pulse on hold_start makes it refuse results for a
    // hold-off counted down in hold_left; otherwise it stalls at random.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            hold_left    <= 0;
            out_ch.ready <= 1'b0;
        end else if (hold_start) begin
            hold_left    <= HOLD_CYCLES;
            out_ch.ready <= 1'b0;
        end else if (hold_left != 0) begin
            hold_left    <= hold_left - 1;
            out_ch.ready <= 1'b0;
        end else begin
            out_ch.ready <= ($urandom_range(99) >= sink_stall_pct);
        end
    end

    // Offers one transaction and returns at the edge that accepts it. Valid is
    // left high, so a following transaction can go out back to back; it is
    // lowered only when the sender chooses to idle.
    task automatic send_item(input hdec_pkg::t_in_item item);
        while ($urandom_range(99) < send_idle_pct) begin
            in_ch.valid <= 1'b0;
            @(posedge i_clk);
        end
        in_ch.valid <= 1'b1;
        in_ch.data  <= item;
        @(posedge i_clk);
        while (in_ch.ready !== 1'b1) @(posedge i_clk);
    endtask

    // Fields a transaction does not use are filled with noise.
    function automatic hdec_pkg::t_in_item noise_item(input logic [1:0] op);
        logic [63:0]        noise;
        hdec_pkg::t_in_item item;
        noise   = {$urandom, $urandom};
        item    = noise[$bits(hdec_pkg::t_in_item)-1:0];
        item.op = op;
        return item;
    endfunction

    task automatic load_node(input logic [hdec_pkg::IDX_W-1:0] idx, input logic leaf,
                             input logic [hdec_pkg::SYM_W-1:0] sym,
                             input logic [hdec_pkg::IDX_W-1:0] left,
                             input logic [hdec_pkg::IDX_W-1:0] right);
        hdec_pkg::t_in_item item;
        item              = noise_item(hdec_pkg::OP_LOAD);
        item.node_index   = idx;
        item.node_is_leaf = leaf;
        item.node_symbol  = sym;
        item.left_child   = left;
        item.right_child  = right;
        loaded_nodes.push_back(idx);
        item_count++;
        send_item(item);
    endtask

    task automatic send_byte(input logic [7:0] data);
        hdec_pkg::t_in_item item;
        item           = noise_item(hdec_pkg::OP_DATA);
        item.data_byte = data;
        item_count++;
        send_item(item);
    endtask

    task automatic send_end();
        item_count++;
        send_item(noise_item(hdec_pkg::OP_END));
    endtask

    // Waits until the block owes no result and has gone quiet. The first edge
    // lets the checker account for the transaction accepted last.
    task automatic settle();
        in_ch.valid <= 1'b0;
        @(posedge i_clk);
        while (results_owed != 0) @(posedge i_clk);
        repeat (QUIET_CYCLES) @(posedge i_clk);
    endtask

    // Writes both registers on consecutive edges; only called after settle().
    task automatic configure(input logic [31:0] total,
                             input logic [hdec_pkg::IDX_W-1:0] root);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= hdec_pkg::CFG_TOTAL;
        i_cfg_data <= total;
        @(posedge i_clk);
        i_cfg_idx  <= hdec_pkg::CFG_ROOT;
        i_cfg_data <= hdec_pkg::CFG_DATA_W'(root);
        @(posedge i_clk);
        i_cfg_we   <= 1'b0;
    endtask

    function automatic logic [hdec_pkg::IDX_W-1:0] fresh_slot();
        logic [hdec_pkg::IDX_W-1:0] slot;
        do slot = hdec_pkg::IDX_W'($urandom_range(511)); while (tree_used[slot]);
        tree_used[slot] = 1'b1;
        return slot;
    endfunction

    // Builds a random code tree bottom up at scattered table slots. Children are
    // always loaded before their parent, so every inner node in the table points
    // at loaded entries and the walk never reaches an unloaded one.
    task automatic build_tree(input int leaves, output logic [hdec_pkg::IDX_W-1:0] root);
        logic [hdec_pkg::IDX_W-1:0] pool [$];
        logic [hdec_pkg::IDX_W-1:0] a;
        logic [hdec_pkg::IDX_W-1:0] b;
        logic [hdec_pkg::IDX_W-1:0] slot;
        int                         k;
        foreach (tree_used[i]) tree_used[i] = 1'b0;
        for (k = 0; k < leaves; k++) begin
            slot = fresh_slot();
            load_node(slot, 1'b1, hdec_pkg::SYM_W'($urandom),
                      hdec_pkg::IDX_W'($urandom), hdec_pkg::IDX_W'($urandom));
            pool.push_back(slot);
        end
        while (pool.size() > 1) begin
            k = $urandom_range(pool.size() - 1);
            a = pool[k];
            pool.delete(k);
            k = $urandom_range(pool.size() - 1);
            b = pool[k];
            pool.delete(k);
            slot = fresh_slot();
            load_node(slot, 1'b0, hdec_pkg::SYM_W'($urandom), a, b);
            pool.push_back(slot);
        end
        root = pool[0];
    endtask

    // One well-formed stream: a fresh tree, a symbol total, a run of data bytes
    // with some noise mixed in, and usually an end-of-stream transaction. With
    // with_hold set, the receiver holds off while the bytes keep coming.
    task automatic run_stream(input bit with_hold);
        logic [hdec_pkg::IDX_W-1:0] root;
        logic [31:0]                total;
        int                         leaves;
        int                         bytes;
        int                         k;
        case ($urandom_range(15))
            0:       leaves = 1;
            1:       leaves = $urandom_range(20, 48);
            default: leaves = $urandom_range(2, 9);
        endcase
        build_tree(leaves, root);
        settle();
        case ($urandom_range(7))
            0:       total = '0;
            1:       total = '1;
            2, 3:    total = $urandom_range(1, 24);
            4:       total = $urandom;
            default: total = $urandom_range(25, 200);
        endcase
        if (with_hold) total = '1;
        configure(total, root);
        if (with_hold) begin
            hold_start <= 1'b1;
            @(posedge i_clk);
            hold_start <= 1'b0;
            for (k = 0; k < 10; k++) send_byte(8'($urandom));
        end else begin
            bytes = $urandom_range(3, 12);
            for (k = 0; k < bytes; k++) begin
                case ($urandom_range(19))
                    0: send_item(noise_item(OP_UNUSED));
                    1: load_node(hdec_pkg::IDX_W'($urandom), 1'b1,
                                 hdec_pkg::SYM_W'($urandom),
                                 hdec_pkg::IDX_W'($urandom), hdec_pkg::IDX_W'($urandom));
                    2: load_node(hdec_pkg::IDX_W'($urandom), 1'b0,
                                 hdec_pkg::SYM_W'($urandom),
                                 loaded_nodes[$urandom_range(loaded_nodes.size() - 1)],
                                 loaded_nodes[$urandom_range(loaded_nodes.size() - 1)]);
                    3: send_end();
                    default: send_byte(8'($urandom));
                endcase
            end
        end
        // Now and then the stream runs on into the next one without an end.
        if ($urandom_range(4) != 0) send_end();
    endtask

    initial begin
        int phase;
        i_rst_n        = 1'b0;
        in_ch.valid    = 1'b0;
        in_ch.data     = '0;
        i_cfg_we       = 1'b0;
        i_cfg_idx      = hdec_pkg::CFG_TOTAL;
        i_cfg_data     = '0;
        hold_start     = 1'b0;
        send_idle_pct  = 0;
        sink_stall_pct = 0;
        item_count     = 0;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed part. Node 0 is the root: a 0 bit gives symbol 00, the
        // codes 10 and 11 give A5 and FF. The slots sit at both ends of the
        // table so the index fields see their extremes.
        load_node(9'd1,   1'b1, 8'h00, 9'h1FF, 9'h000);
        load_node(9'd511, 1'b1, 8'hFF, 9'h000, 9'h1FF);
        load_node(9'd256, 1'b1, 8'hA5, 9'h0AA, 9'h155);
        load_node(9'd2,   1'b0, 8'hFF, 9'd256, 9'd511);
        load_node(9'd0,   1'b0, 8'h00, 9'd1,   9'd2);
        settle();

        // A total of zero decodes nothing, and the stream counts as complete.
        configure('0, 9'd0);
        send_byte(8'hFF);
        send_end();
        settle();

        // Unbounded total: all zeros, all ones, mixed codes, and a byte that stops
        // halfway down the tree; the end reports a broken stream: total not met.
        configure('1, 9'd0);
        send_byte(8'h00);
        send_byte(8'hFF);
        send_byte(8'hB6);
        send_byte(8'h01);
        send_end();
        send_item(noise_item(OP_UNUSED));
        settle();

        // A leaf as root yields one symbol per bit; the total stops the byte
        // after five and the next byte is ignored.
        configure(32'd5, 9'd511);
        send_byte(8'h3C);
        send_byte(8'hAA);
        send_end();
        settle();

        // Leave the walk inside the tree, then move the root, which also moves
        // the walk.
        configure('1, 9'd0);
        send_byte(8'h01);
        settle();
        configure('1, 9'd2);
        send_byte(8'h00);
        send_end();
        settle();

        // Random part, one phase per idling pattern. The long receiver
        // hold-off happens in the first phase, where nothing else idles.
        for (phase = 0; phase < 4; phase++) begin
            case (phase)
                0:       begin send_idle_pct = 0;  sink_stall_pct = 0;  end
                1:       begin send_idle_pct = 48; sink_stall_pct = 0;  end
                2:       begin send_idle_pct = 0;  sink_stall_pct = 48; end
                default: begin send_idle_pct = 34; sink_stall_pct = 34; end
            endcase
            item_count = 0;
            if (phase == 0) run_stream(1'b1);
            while (item_count < PHASE_ITEMS) run_stream(1'b0);
        end
        settle();

        if (mismatches == 0 && results_owed == 0) begin
            $display("** huffman_tree_byte_decoder: PASSED **");
        end else begin
            $display("** huffman_tree_byte_decoder: FAILED **");
        end
        $finish;
    end

    // Watchdog: far beyond the slowest correct run.
    initial begin
        #5_000_000;
        $display("** huffman_tree_byte_decoder: FAILED **");
        $finish;
    end

endmodule
